### rtl/core/fwsm_pkg.sv
// Shared widths, codes and reset values for the four-voice wave synth mixer.
package fwsm_pkg;

  localparam int VOICES_DEF = 4;
  localparam int VOICE_W    = 2;
  localparam int SEL_W      = 3;
  localparam int VAL_W      = 16;
  localparam int PHASE_W    = 16;
  localparam int VOL_W      = 8;
  localparam int WAVE_W     = 3;
  localparam int LEVEL_W    = 6;
  localparam int MIX_W      = 16;
  localparam int SAMPLE_W   = 8;
  localparam int FRAME_W    = 8;
  localparam int LFSR_W     = 32;

  localparam logic [FRAME_W-1:0] FRAME_PERIOD_RESET = 8'd179;
  localparam logic [LFSR_W-1:0]  LFSR_SEED          = 32'h0000_0001;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [SEL_W-1:0] {
    FS_FREQ      = 3'd0,
    FS_DUTY      = 3'd1,
    FS_VOLUME    = 3'd2,
    FS_WAVE      = 3'd3,
    FS_PHASE_ADD = 3'd4
  } field_sel_t;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_TRI   = 3'd0,
    WAVE_SAW   = 3'd1,
    WAVE_PULSE = 3'd2,
    WAVE_NOISE = 3'd3
  } wave_t;

endpackage

### rtl/core/fwsm_if.sv
// Valid/ready channel interfaces for the input words and the sample words.
interface fwsm_in_if;
  import fwsm_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [VOICE_W-1:0] voice;
  logic [SEL_W-1:0]   field_select;
  logic [VAL_W-1:0]   write_value;

  modport source (output valid, kind, voice, field_select, write_value, input ready);
  modport sink   (input valid, kind, voice, field_select, write_value, output ready);
endinterface

interface fwsm_out_if;
  import fwsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_due;

  modport source (output valid, sample, frame_due, input ready);
  modport sink   (input valid, sample, frame_due, output ready);
endinterface

### rtl/core/four_voice_wave_synth_mixer_unit.sv
// Four-voice wave synth mixer: takes one word per cycle, either a voice register write (no
// output) or a sample tick that yields one 8-bit sample in the next cycle from the output
// register; the whole tick (LFSR step, four waveform levels, volume products, mix, frame
// countdown) is one pass of logic between the voice state registers and the output register,
// so the sustained rate is one word per clock while the sink takes samples, and input ready
// drops only while a sample sits unclaimed in the output register.
module four_voice_wave_synth_mixer_unit #(
  parameter int VOICES = fwsm_pkg::VOICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fwsm_pkg::FRAME_W-1:0] cfg_wdata,
  fwsm_in_if.sink                      in_ch,
  fwsm_out_if.source                   out_ch
);
  import fwsm_pkg::*;

  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [PHASE_W-1:0] step_r  [VOICES];
  logic [PHASE_W-1:0] duty_r  [VOICES];
  logic [VOL_W-1:0]   vol_r   [VOICES];
  logic [WAVE_W-1:0]  wave_r  [VOICES];
  logic [LFSR_W-1:0]  lfsr_r;
  logic [FRAME_W-1:0] cnt_r;
  logic [FRAME_W-1:0] period_r;
  logic               out_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic               frame_due_r;

  logic                             in_ready;
  logic                             tick;
  logic                             wr;
  logic [LFSR_W-1:0]                lfsr_nxt;
  logic [FRAME_W-1:0]               cnt_nxt;
  logic                             frame_hit;
  logic signed [LEVEL_W-1:0]        noise_lvl;
  logic signed [LEVEL_W-1:0]        lvl  [VOICES];
  logic signed [LEVEL_W+VOL_W:0]    prod [VOICES];
  logic signed [MIX_W-1:0]          mix;
  logic [SAMPLE_W-1:0]              sample_nxt;

  function automatic logic signed [LEVEL_W-1:0] level_of(
    input logic [PHASE_W-1:0]        ph,
    input logic [PHASE_W-1:0]        duty,
    input logic [WAVE_W-1:0]         wave,
    input logic signed [LEVEL_W-1:0] noise
  );
    logic signed [LEVEL_W-1:0] lv;
    case (wave_t'(wave))
      // rising half counts up from -32, falling half counts down from 31
      WAVE_TRI:   lv = ph[PHASE_W-1] ? {ph[PHASE_W-2], ~ph[PHASE_W-3 -: LEVEL_W-1]}
                                     : {~ph[PHASE_W-2], ph[PHASE_W-3 -: LEVEL_W-1]};
      WAVE_SAW:   lv = {~ph[PHASE_W-1], ph[PHASE_W-2 -: LEVEL_W-1]};
      WAVE_PULSE: lv = (ph > duty) ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
      WAVE_NOISE: lv = noise;
      default:    lv = '0;
    endcase
    return lv;
  endfunction

  always_comb begin
    in_ready = !out_valid_r || out_ch.ready;
    tick     = in_ch.valid && in_ready && (kind_t'(in_ch.kind) == KIND_TICK);
    wr       = in_ch.valid && in_ready && (kind_t'(in_ch.kind) == KIND_WRITE);

    lfsr_nxt  = {lfsr_r[LFSR_W-2:0], lfsr_r[31] ^ lfsr_r[24] ^ lfsr_r[9] ^ lfsr_r[6]};
    // low six bits minus 32: flip the top bit
    noise_lvl = {~lfsr_nxt[LEVEL_W-1], lfsr_nxt[LEVEL_W-2:0]};

    frame_hit = (cnt_r == '0);
    cnt_nxt   = frame_hit ? period_r : cnt_r - 1'b1;

    mix = '0;
    for (int v = 0; v < VOICES; v++) begin
      lvl[v]  = level_of(phase_r[v], duty_r[v], wave_r[v], noise_lvl);
      prod[v] = lvl[v] * $signed({1'b0, vol_r[v]});
      mix     = mix + MIX_W'(prod[v]);
    end
    // add the mid level by flipping the sign bit, then keep the top byte
    sample_nxt = {~mix[MIX_W-1], mix[MIX_W-2 -: SAMPLE_W-1]};
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sample    = sample_r;
  assign out_ch.frame_due = frame_due_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICES; v++) begin
        phase_r[v] <= '0;
        step_r[v]  <= '0;
        duty_r[v]  <= '0;
        vol_r[v]   <= '0;
        wave_r[v]  <= WAVE_TRI;
      end
      lfsr_r      <= LFSR_SEED;
      cnt_r       <= '0;
      period_r    <= FRAME_PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (tick) begin
        lfsr_r <= lfsr_nxt;
        cnt_r  <= cnt_nxt;
        for (int v = 0; v < VOICES; v++) begin
          phase_r[v] <= phase_r[v] + step_r[v];
        end
      end
      if (wr) begin
        // writes to an absent voice match no lane and drop
        for (int v = 0; v < VOICES; v++) begin
          if (in_ch.voice == VOICE_W'(v)) begin
            case (field_sel_t'(in_ch.field_select))
              FS_FREQ:      step_r[v]  <= in_ch.write_value;
              FS_DUTY:      duty_r[v]  <= in_ch.write_value;
              FS_VOLUME:    vol_r[v]   <= in_ch.write_value[VOL_W-1:0];
              FS_WAVE:      wave_r[v]  <= in_ch.write_value[WAVE_W-1:0];
              FS_PHASE_ADD: phase_r[v] <= phase_r[v] + in_ch.write_value;
              default: ;
            endcase
          end
        end
      end
      out_valid_r <= tick || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      sample_r    <= sample_nxt;
      frame_due_r <= frame_hit;
    end
  end

endmodule

### rtl/core/fwsm_checker.sv
// Port-level checks for the four-voice wave synth mixer, bound to the top level.
module fwsm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fwsm_pkg::SAMPLE_W-1:0] out_sample
);
  import fwsm_pkg::*;

  // hold the word while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("sample word changed while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output register is full");

  a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_TICK) |=> out_valid)
    else $error("tick gave no sample word");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_WRITE) |=> !out_valid)
    else $error("register write produced a sample word");

  // four voices at full negative swing floor to zero, so only the top is bounded
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample <= SAMPLE_W'(251)))
    else $error("sample out of mix range");

endmodule

bind four_voice_wave_synth_mixer_unit fwsm_checker u_fwsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample)
);
